// ===== design/sarx_pkg.sv =====
// Shared types and constants for the segmented acknowledge link receiver.
package sarx_pkg;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  // Begin byte that opens a transfer; the acknowledge byte itself (0x06)
  // is produced by the transmit side when send_ack is raised.
  localparam logic [ByteW-1:0] BeginByte = 8'h01;

  // Capacity after reset.
  localparam logic [CountW-1:0] CapacityReset = 16'hFFFF;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OutDataW = 48;

  // One result transaction.
  typedef struct packed {
    logic [CountW-1:0] stored_total;
    logic              transfer_done;
    logic              dropped;
    logic [ByteW-1:0]  store_byte;
    logic [CountW-1:0] store_index;
    logic              store_valid;
    logic              send_ack;
  } result_t;

endpackage

// ===== design/sarx_ctrl.sv =====
// Receive state machine: decodes one byte per step and forms its result.
module sarx_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [sarx_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [sarx_pkg::CountW-1:0]   capacity_i,
  output sarx_pkg::result_t             result_o
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhLength  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [sarx_pkg::ByteW-1:0]    left_q, left_d;
  logic [sarx_pkg::CountW-1:0]   count_q, count_d;
  logic [sarx_pkg::ByteW-1:0]    left_dec;

  assign left_dec = left_q - 8'd1;

  // Next state and result for the byte at the head of the input stage.
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    count_d  = count_q;
    result_o = '0;
    case (phase_q)
      PhLength: begin
        if (rx_byte_i == '0) begin
          // A zero length closes the transfer and reports the total.
          result_o.send_ack      = 1'b1;
          result_o.transfer_done = 1'b1;
          result_o.stored_total  = count_q;
          count_d = '0;
          left_d  = '0;
          phase_d = PhIdle;
        end else begin
          left_d  = rx_byte_i;
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        if (count_q < capacity_i) begin
          result_o.store_valid = 1'b1;
          result_o.store_index = count_q;
          result_o.store_byte  = rx_byte_i;
          count_d = count_q + 16'd1;
        end else begin
          result_o.dropped = 1'b1;
        end
        left_d = left_dec;
        // The last byte of a segment is acknowledged.
        if (left_dec == '0) begin
          result_o.send_ack = 1'b1;
          phase_d = PhLength;
        end
      end
      default: begin
        // Idle, and the unused phase code behaves as idle.
        phase_d = PhIdle;
        if (rx_byte_i == sarx_pkg::BeginByte) begin
          result_o.send_ack = 1'b1;
          count_d = '0;
          left_d  = '0;
          phase_d = PhLength;
        end
      end
    endcase
  end

  // State advances only when a byte moves on to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      left_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== design/sarx_out_reg.sv =====
// Result register that holds one finished transaction until it is taken.
module sarx_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sarx_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              valid_o,
  output sarx_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  sarx_pkg::result_t result_q;

  // A load always wins; otherwise a taken result empties the register.
  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== design/segmented_ack_link_receiver_core.sv =====
// Top level of the segmented acknowledge link receiver.
// A byte accepted into the input register shows its result once it has moved on into the result register.
// Throughput: one byte per cycle, set by the single-step state update between
// the input register and the result register; the input stalls only when the
// result register is full and not being taken.
// Reset: asynchronous and active low; returns to idle, clears counts, capacity 65535.
module segmented_ack_link_receiver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: buffer_capacity.
  input  logic                          cfg_we_i,
  input  logic [sarx_pkg::CountW-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] send_ack, [1] store_valid, [17:2] store_index, [25:18] store_byte,
  // [26] dropped, [42:27] stored_total, [47:43] zero
  output logic [sarx_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // transfer_done
);

  logic [sarx_pkg::CountW-1:0] capacity_q;
  logic                        in_valid_q;
  logic [sarx_pkg::ByteW-1:0]  in_byte_q;
  logic                        advance;
  sarx_pkg::result_t           step_result;
  sarx_pkg::result_t           out_result;
  logic                        out_valid;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= sarx_pkg::CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // The held byte moves on whenever the result register has room.
  assign advance       = in_valid_q && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sarx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .rx_byte_i  (in_byte_q),
    .capacity_i (capacity_q),
    .result_o   (step_result)
  );

  sarx_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (step_result),
    .ready_i  (m_axis_tready),
    .valid_o  (out_valid),
    .result_o (out_result)
  );

  // Pack the result transaction onto the output stream.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_result.transfer_done;
  assign m_axis_tdata  = {5'd0,
                          out_result.stored_total,
                          out_result.dropped,
                          out_result.store_byte,
                          out_result.store_index,
                          out_result.store_valid,
                          out_result.send_ack};

endmodule

// ===== design/sarx_checker.sv =====
// Port-level assertions for the receiver core, bound to the top level.
module sarx_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sarx_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // A stalled result transaction holds its contents.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The end of a transfer is always acknowledged.
  a_done_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0])
    else $error("transfer end without acknowledge");

  // A payload byte is either stored or dropped, never both.
  a_store_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[26]))
    else $error("byte both stored and dropped");

  // The total is reported only with the end of a transfer.
  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[42:27] == '0)
    else $error("total outside transfer end");

endmodule

bind segmented_ack_link_receiver_core sarx_checker u_sarx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/segmented_ack_link_checker.sv =====
// Checker that predicts and compares every result of the segmented acknowledge link receiver.
`timescale 1ns / 100ps
module segmented_ack_link_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sarx_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          rx_valid_i,
  input  logic                          rx_ready_i,
  input  logic [sarx_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [sarx_pkg::OutDataW-1:0] res_data_i,
  input  logic                          res_last_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   mismatches_o
);

  typedef enum logic [1:0] {
    LinkIdle    = 2'd0,
    LinkLength  = 2'd1,
    LinkPayload = 2'd2
  } link_phase_e;

  // A length byte of zero closes the transfer.
  localparam logic [sarx_pkg::ByteW-1:0] EndLength = 8'h00;

  link_phase_e                  link_phase = LinkIdle;
  logic [sarx_pkg::ByteW-1:0]   seg_left   = '0;
  logic [sarx_pkg::CountW-1:0]  stored_cnt = '0;
  logic [sarx_pkg::CountW-1:0]  capacity   = sarx_pkg::CapacityReset;
  sarx_pkg::result_t            link_results_q[$];

  initial begin
    outstanding_o = 0;
    mismatches_o  = 0;
  end

  // Works out the result of one received byte and advances the link state.
  function automatic sarx_pkg::result_t link_response(input logic [sarx_pkg::ByteW-1:0] rx);
    sarx_pkg::result_t res;
    res = '0;
    case (link_phase)
      LinkLength: begin
        if (rx == EndLength) begin
          res.send_ack      = 1'b1;
          res.transfer_done = 1'b1;
          res.stored_total  = stored_cnt;
          stored_cnt        = '0;
          seg_left          = '0;
          link_phase        = LinkIdle;
        end else begin
          seg_left   = rx;
          link_phase = LinkPayload;
        end
      end
      LinkPayload: begin
        // Payload is stored only while there is room left in the buffer.
        if (stored_cnt < capacity) begin
          res.store_valid = 1'b1;
          res.store_index = stored_cnt;
          res.store_byte  = rx;
          stored_cnt      = stored_cnt + 1'b1;
        end else begin
          res.dropped = 1'b1;
        end
        seg_left = seg_left - 1'b1;
        if (seg_left == '0) begin
          res.send_ack = 1'b1;
          link_phase   = LinkLength;
        end
      end
      default: begin
        // Outside a transfer only the begin byte has any effect.
        link_phase = LinkIdle;
        if (rx == sarx_pkg::BeginByte) begin
          res.send_ack = 1'b1;
          stored_cnt   = '0;
          seg_left     = '0;
          link_phase   = LinkLength;
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare accepted results first, then queue the prediction for a new byte.
  always @(posedge clk_i or negedge rst_ni) begin
    sarx_pkg::result_t want;
    sarx_pkg::result_t got;
    if (!rst_ni) begin
      link_phase = LinkIdle;
      seg_left   = '0;
      stored_cnt = '0;
      capacity   = sarx_pkg::CapacityReset;
      link_results_q.delete();
      outstanding_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got               = '0;
        got.send_ack      = res_data_i[0];
        got.store_valid   = res_data_i[1];
        got.store_index   = res_data_i[17:2];
        got.store_byte    = res_data_i[25:18];
        got.dropped       = res_data_i[26];
        got.stored_total  = res_data_i[42:27];
        got.transfer_done = res_last_i;
        if (link_results_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected transaction, expected none, actual %h last %b",
                   $time, res_data_i, res_last_i);
        end else begin
          want = link_results_q.pop_front();
          check_field("send_ack", 16'(want.send_ack), 16'(got.send_ack));
          check_field("store_valid", 16'(want.store_valid), 16'(got.store_valid));
          check_field("store_index", want.store_index, got.store_index);
          check_field("store_byte", 16'(want.store_byte), 16'(got.store_byte));
          check_field("dropped", 16'(want.dropped), 16'(got.dropped));
          check_field("transfer_done", 16'(want.transfer_done), 16'(got.transfer_done));
          check_field("stored_total", want.stored_total, got.stored_total);
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        link_results_q.push_back(link_response(rx_byte_i));
      end
      // The new capacity applies from the next byte on.
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      outstanding_o = link_results_q.size();
    end
  end

endmodule

// ===== tb/sv/segmented_ack_link_receiver_core_tb.sv =====
// Testbench top that drives bytes and capacity settings into the link receiver and gives the verdict.
`timescale 1ns / 100ps
module segmented_ack_link_receiver_core_tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam logic [7:0]  EndLength     = 8'h00;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [sarx_pkg::CountW-1:0]   cfg_wdata;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [sarx_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;

  int unsigned results_pending;
  int unsigned mismatches;
  int unsigned bytes_sent   = 0;
  int unsigned stall_cycles = 0;
  bit          tx_gaps      = 1'b1;
  bit          rx_gaps      = 1'b1;
  bit          hold_rx      = 1'b0;

  always #5 clk = ~clk;

  segmented_ack_link_receiver_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  segmented_ack_link_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .rx_valid_i   (s_axis_tvalid),
    .rx_ready_i   (s_axis_tready),
    .rx_byte_i    (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_last_i   (m_axis_tlast),
    .outstanding_o(results_pending),
    .mismatches_o (mismatches)
  );

  // Offers one byte, possibly after a short gap, and waits for the transaction.
  task automatic push_byte(input logic [7:0] value);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [sarx_pkg::CountW-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One transfer with random segments; now and then idle noise first, or cut short.
  task automatic send_transfer();
    int unsigned segs;
    int unsigned len;
    int unsigned seg;
    bit          cut;
    logic [7:0]  rx;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        do rx = 8'($urandom_range(0, 255)); while (rx == sarx_pkg::BeginByte);
        push_byte(rx);
      end
    end
    push_byte(sarx_pkg::BeginByte);
    segs = $urandom_range(0, 5);
    cut  = ($urandom_range(0, 11) == 0);
    for (seg = 0; seg < segs; seg++) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
      push_byte(8'(len));
      if (cut && seg == segs - 1) begin
        len = $urandom_range(0, len - 1);
      end
      repeat (len) push_byte(8'($urandom_range(0, 255)));
    end
    if (!cut) begin
      push_byte(EndLength);
    end
  endtask

  task automatic run_phase(input logic [sarx_pkg::CountW-1:0] cap, input int unsigned quota,
                           input bit hold);
    int unsigned stop_at;
    write_capacity(cap);
    if (hold) begin
      hold_rx = 1'b1;
    end
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) send_transfer();
  endtask

  // Result side: ready with random stalls, and one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Ends the run when no transaction has happened on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Idle bytes are ignored; the begin byte serves as a length and as payload.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(sarx_pkg::BeginByte);
    push_byte(sarx_pkg::BeginByte);
    push_byte(sarx_pkg::BeginByte);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(EndLength);

    // With no room at all every payload byte is dropped.
    write_capacity(16'h0000);
    push_byte(sarx_pkg::BeginByte);
    push_byte(8'h02);
    push_byte(8'hAA);
    push_byte(8'h55);
    push_byte(EndLength);

    // Capacity runs out mid-segment, then grows while the transfer is still open.
    write_capacity(16'h0002);
    push_byte(sarx_pkg::BeginByte);
    push_byte(8'h03);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(8'hC3);
    write_capacity(16'h0004);
    push_byte(8'h01);
    push_byte(8'h3C);
    push_byte(EndLength);

    run_phase(16'hFFFF, 280, 1'b0);
    run_phase(16'h0000, 250, 1'b1);
    run_phase(16'h0001, 250, 1'b0);
    run_phase(16'($urandom_range(2, 60)), 280, 1'b0);
    run_phase(16'($urandom_range(61, 400)), 280, 1'b0);

    // Closing stretch at full rate on both sides.
    drain_results();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_phase(16'hFFFF, 200, 1'b0);
    drain_results();

    if (mismatches == 0 && results_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sarx_pkg.sv
design/sarx_ctrl.sv
design/sarx_out_reg.sv
design/segmented_ack_link_receiver_core.sv
design/sarx_checker.sv
tb/sv/segmented_ack_link_checker.sv
tb/sv/segmented_ack_link_receiver_core_tb.sv
